### rtl/bqeq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bqeq_pkg;

    localparam int BANDS      = 10;
    localparam int COEFS      = 5;
    localparam int COEF_DEPTH = BANDS * COEFS;
    localparam int COEF_AW    = $clog2(COEF_DEPTH);
    localparam int BAND_W     = (BANDS > 1) ? $clog2(BANDS) : 1;

    localparam int OP_W     = 2;
    localparam int SAMPLE_W = 24;
    localparam int BSEL_W   = 4;
    localparam int CIDX_W   = 3;
    localparam int COEF_W   = 32;
    localparam int DLY_W    = 40;
    localparam int PROD_W   = COEF_W + SAMPLE_W;
    localparam int P_W      = PROD_W - 20;
    localparam int ACC_W    = DLY_W + 2;

    localparam logic signed [COEF_W-1:0] COEF_ONE = 32'sh1000_0000;

    typedef enum logic [OP_W-1:0] {
        OP_FILTER = 2'd0,
        OP_WRITE  = 2'd1,
        OP_CLEAR  = 2'd2
    } op_t;

    typedef enum logic [CIDX_W-1:0] {
        COEF_B0 = 3'd0,
        COEF_B1 = 3'd1,
        COEF_B2 = 3'd2,
        COEF_A1 = 3'd3,
        COEF_A2 = 3'd4
    } coef_idx_t;

    typedef enum logic [2:0] {
        ALU_NONE,
        ALU_Y,
        ALU_N1_INIT,
        ALU_N1_SUB,
        ALU_N2_INIT,
        ALU_WB
    } alu_op_t;

    typedef struct packed {
        logic              start;
        logic              coef_wr;
        logic              dly_clear;
        logic              coef_rd;
        coef_idx_t         coef_sel;
        logic              dly_rd;
        logic [BAND_W-1:0] band;
        logic              mul_en;
        logic              mul_y;
        logic              zload;
        alu_op_t           alu;
        logic              out_load;
    } dp_cmd_t;

endpackage

`default_nettype wire

### rtl/bqeq_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface bqeq_in_if import bqeq_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [OP_W-1:0]            operation;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic [BSEL_W-1:0]          band_select;
    logic [CIDX_W-1:0]          coef_index;
    logic signed [COEF_W-1:0]   coef_value;

    modport source (
        output valid, operation, sample_in, band_select, coef_index, coef_value,
        input  ready
    );

    modport sink (
        input  valid, operation, sample_in, band_select, coef_index, coef_value,
        output ready
    );
endinterface

`default_nettype wire

### rtl/bqeq_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface bqeq_out_if import bqeq_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_out;

    modport source (
        output valid, sample_out,
        input  ready
    );

    modport sink (
        input  valid, sample_out,
        output ready
    );
endinterface

`default_nettype wire

### rtl/bqeq_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module bqeq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0]      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### rtl/bqeq_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module bqeq_datapath import bqeq_pkg::*; (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire dp_cmd_t                    cmd,
    input  wire logic signed [SAMPLE_W-1:0] sample_in,
    input  wire logic [BSEL_W-1:0]          band_select,
    input  wire logic [CIDX_W-1:0]          coef_index,
    input  wire logic signed [COEF_W-1:0]   coef_value,
    output logic signed [SAMPLE_W-1:0]      sample_out
);

    localparam int YF_W = ACC_W - 8;

    function automatic logic signed [SAMPLE_W-1:0] sat_y(input logic signed [YF_W-1:0] v);
        logic [YF_W-SAMPLE_W:0] top;
        top = v[YF_W-1:SAMPLE_W-1];
        if (top == '0 || top == '1)
            return v[SAMPLE_W-1:0];
        else if (v[YF_W-1])
            return {1'b1, {(SAMPLE_W-1){1'b0}}};
        else
            return {1'b0, {(SAMPLE_W-1){1'b1}}};
    endfunction

    function automatic logic signed [DLY_W-1:0] sat_d(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-DLY_W:0] top;
        top = v[ACC_W-1:DLY_W-1];
        if (top == '0 || top == '1)
            return v[DLY_W-1:0];
        else if (v[ACC_W-1])
            return {1'b1, {(DLY_W-1){1'b0}}};
        else
            return {1'b0, {(DLY_W-1){1'b1}}};
    endfunction

    logic                       coef_wr_en;
    logic [COEF_AW-1:0]         coef_wr_addr;
    logic [COEF_AW-1:0]         coef_rd_addr;
    logic [COEF_W-1:0]          coef_rdata;
    logic signed [COEF_W-1:0]   coef_q;
    logic [COEF_DEPTH-1:0]      coef_vld_reg, coef_vld_next;
    logic                       coef_rd_vld_reg;
    logic                       coef_rd_b0_reg;

    logic                       dly_wr_en;
    logic [2*DLY_W-1:0]         dly_rdata;
    logic [BANDS-1:0]           dly_vld_reg, dly_vld_next;
    logic                       dly_rd_vld_reg;
    logic [BAND_W-1:0]          wb_band_reg;

    logic signed [SAMPLE_W-1:0] x_reg, y_reg, out_reg;
    logic signed [SAMPLE_W-1:0] mul_v;
    logic signed [PROD_W-1:0]   prod_reg, prod_rnd;
    logic signed [P_W-1:0]      p;
    logic signed [DLY_W-1:0]    z1_reg, z2_reg;
    logic signed [DLY_W-1:0]    d1, d2;
    logic signed [ACC_W-1:0]    n1_reg, n2_reg;
    logic signed [ACC_W-1:0]    acc, acc_rnd, n2_fin;
    logic signed [SAMPLE_W-1:0] y_new;

    // coefficient store
    assign coef_wr_en = cmd.coef_wr && (int'(band_select) < BANDS)
                        && (int'(coef_index) < COEFS);
    assign coef_wr_addr = COEF_AW'(int'(band_select) * COEFS + int'(coef_index));
    assign coef_rd_addr = COEF_AW'(int'(cmd.band) * COEFS + int'(cmd.coef_sel));

    bqeq_ram #(
        .WIDTH (COEF_W),
        .DEPTH (COEF_DEPTH)
    ) u_coef_ram (
        .clk     (clk),
        .wr_en   (coef_wr_en),
        .wr_addr (coef_wr_addr),
        .wr_data (coef_value),
        .rd_en   (cmd.coef_rd),
        .rd_addr (coef_rd_addr),
        .rd_data (coef_rdata)
    );

    // never-written entries read as pass-through: b0 = 1.0, rest 0
    always_comb
    begin
        if (coef_rd_vld_reg)
            coef_q = coef_rdata;
        else if (coef_rd_b0_reg)
            coef_q = COEF_ONE;
        else
            coef_q = '0;
    end

    always_comb
    begin
        coef_vld_next = coef_vld_reg;
        if (coef_wr_en)
        begin
            coef_vld_next[coef_wr_addr] = 1'b1;
        end
    end

    // delay store: one row {z2, z1} per band
    assign dly_wr_en = (cmd.alu == ALU_WB);

    bqeq_ram #(
        .WIDTH (2 * DLY_W),
        .DEPTH (BANDS)
    ) u_dly_ram (
        .clk     (clk),
        .wr_en   (dly_wr_en),
        .wr_addr (wb_band_reg),
        .wr_data ({d2, d1}),
        .rd_en   (cmd.dly_rd),
        .rd_addr (cmd.band),
        .rd_data (dly_rdata)
    );

    always_comb
    begin
        dly_vld_next = dly_vld_reg;
        if (cmd.dly_clear)
            dly_vld_next = '0;
        else if (dly_wr_en)
            dly_vld_next[wb_band_reg] = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_vld_reg    <= '0;
            coef_rd_vld_reg <= 1'b0;
            coef_rd_b0_reg  <= 1'b0;
            dly_vld_reg     <= '0;
            dly_rd_vld_reg  <= 1'b0;
        end
        else
        begin
            coef_vld_reg <= coef_vld_next;
            dly_vld_reg  <= dly_vld_next;
            if (cmd.coef_rd)
            begin
                coef_rd_vld_reg <= coef_vld_reg[coef_rd_addr];
                coef_rd_b0_reg  <= (cmd.coef_sel == COEF_B0);
            end
            if (cmd.dly_rd)
            begin
                dly_rd_vld_reg <= dly_vld_reg[cmd.band];
            end
        end
    end

    // shared multiply, product rounded half up to 31 fractional bits
    assign mul_v    = cmd.mul_y ? y_reg : x_reg;
    assign prod_rnd = prod_reg + PROD_W'(1 << 19);
    assign p        = prod_rnd[PROD_W-1:20];

    assign acc     = ACC_W'(p) + ACC_W'(z1_reg);
    assign acc_rnd = acc + ACC_W'(128);
    assign y_new   = sat_y(acc_rnd[ACC_W-1:8]);
    assign n2_fin  = n2_reg - ACC_W'(p);
    assign d1      = sat_d(n1_reg);
    assign d2      = sat_d(n2_fin);

    always_ff @(posedge clk)
    begin
        if (cmd.dly_rd)
        begin
            wb_band_reg <= cmd.band;
        end
        if (cmd.start)
        begin
            x_reg <= sample_in;
        end
        else if (cmd.alu == ALU_WB)
        begin
            x_reg <= y_reg;
        end
        if (cmd.mul_en)
        begin
            prod_reg <= PROD_W'(coef_q) * PROD_W'(mul_v);
        end
        if (cmd.zload)
        begin
            z1_reg <= dly_rd_vld_reg ? dly_rdata[DLY_W-1:0] : '0;
            z2_reg <= dly_rd_vld_reg ? dly_rdata[2*DLY_W-1:DLY_W] : '0;
        end
        case (cmd.alu)
            ALU_Y:       y_reg  <= y_new;
            ALU_N1_INIT: n1_reg <= ACC_W'(p) + ACC_W'(z2_reg);
            ALU_N1_SUB:  n1_reg <= n1_reg - ACC_W'(p);
            ALU_N2_INIT: n2_reg <= ACC_W'(p);
            default:     ;
        endcase
        if (cmd.out_load)
        begin
            out_reg <= y_reg;
        end
    end

    assign sample_out = out_reg;

endmodule

`default_nettype wire

### rtl/bqeq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module bqeq_ctrl import bqeq_pkg::*; (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire logic [OP_W-1:0] operation,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output dp_cmd_t              cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_B0,
        S_Y,
        S_N1,
        S_N1SUB,
        S_N2,
        S_WB,
        S_DRAIN
    } state_t;

    localparam logic [BAND_W-1:0] LAST_BAND = BAND_W'(BANDS - 1);

    state_t            state_reg, state_next;
    logic [BAND_W-1:0] band_reg, band_next;
    logic              out_valid_reg, out_valid_next;
    logic              slot_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        cmd            = '0;
        cmd.coef_sel   = COEF_B0;
        cmd.alu        = ALU_NONE;
        cmd.band       = band_reg;
        state_next     = state_reg;
        band_next      = band_reg;
        out_valid_next = out_valid_reg && !out_ready;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (operation)
                        OP_FILTER:
                        begin
                            cmd.start   = 1'b1;
                            cmd.coef_rd = 1'b1;
                            cmd.dly_rd  = 1'b1;
                            cmd.band    = '0;
                            band_next   = '0;
                            state_next  = S_B0;
                        end
                        OP_WRITE: cmd.coef_wr   = 1'b1;
                        OP_CLEAR: cmd.dly_clear = 1'b1;
                        default:  ;
                    endcase
                end
            end
            S_B0:
            begin
                cmd.zload    = 1'b1;
                cmd.mul_en   = 1'b1;
                cmd.coef_rd  = 1'b1;
                cmd.coef_sel = COEF_B1;
                state_next   = S_Y;
            end
            S_Y:
            begin
                cmd.alu      = ALU_Y;
                cmd.mul_en   = 1'b1;
                cmd.coef_rd  = 1'b1;
                cmd.coef_sel = COEF_A1;
                state_next   = S_N1;
            end
            S_N1:
            begin
                cmd.alu      = ALU_N1_INIT;
                cmd.mul_en   = 1'b1;
                cmd.mul_y    = 1'b1;
                cmd.coef_rd  = 1'b1;
                cmd.coef_sel = COEF_B2;
                state_next   = S_N1SUB;
            end
            S_N1SUB:
            begin
                cmd.alu      = ALU_N1_SUB;
                cmd.mul_en   = 1'b1;
                cmd.coef_rd  = 1'b1;
                cmd.coef_sel = COEF_A2;
                state_next   = S_N2;
            end
            S_N2:
            begin
                cmd.alu    = ALU_N2_INIT;
                cmd.mul_en = 1'b1;
                cmd.mul_y  = 1'b1;
                state_next = S_WB;
            end
            S_WB:
            begin
                cmd.alu = ALU_WB;
                if (band_reg == LAST_BAND)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    // fetch b0 and delay row of the next band
                    cmd.band    = BAND_W'(band_reg + 1'b1);
                    cmd.coef_rd = 1'b1;
                    cmd.dly_rd  = 1'b1;
                    band_next   = BAND_W'(band_reg + 1'b1);
                    state_next  = S_B0;
                end
            end
            S_DRAIN:
            begin
                if (slot_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            band_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            band_reg      <= band_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

### rtl/biquad_cascade_equalizer_top.sv
// Ten-band biquad cascade equalizer (transposed direct form II sections).
// item   : input channel, one beat per command. operation selects filter
//          (sample_in), coefficient write (band_select, coef_index,
//          coef_value, Q4.28) or clear of all delay state.
// result : output channel, one beat with sample_out (Q1.23, saturated) for
//          each filter beat; writes and clears produce no beat.
// A filter beat runs the bands one after another through a single shared
// 32x24 multiplier, five products per band. item.ready stays low from the
// accepting edge until the finished beat is loaded into the output register;
// result.valid rises with that load, as ready returns high for the next beat.
// Writes and clears keep ready high.
// Results go through an output register: a stalled receiver holds the
// finished beat there, and the next filter beat is accepted and computed,
// waiting only at its final step until the register is free.
// Reset (rst_n, async, active low) sets every band to pass-through (b0 = 1.0)
// and zeroes all delay state at once through per-entry valid flags; no
// clearing sweep is needed and the block is ready right after reset.
`timescale 1ns / 1ps
`default_nettype none

module biquad_cascade_equalizer_top import bqeq_pkg::*; (
    input  wire logic  clk,
    input  wire logic  rst_n,
    bqeq_in_if.sink    item,
    bqeq_out_if.source result
);

    dp_cmd_t cmd;
    logic    in_ready;
    logic    out_valid;

    bqeq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_ready  (in_ready),
        .operation (item.operation),
        .out_valid (out_valid),
        .out_ready (result.ready),
        .cmd       (cmd)
    );

    bqeq_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sample_in   (item.sample_in),
        .band_select (item.band_select),
        .coef_index  (item.coef_index),
        .coef_value  (item.coef_value),
        .sample_out  (result.sample_out)
    );

    assign item.ready   = in_ready;
    assign result.valid = out_valid;

endmodule

`default_nettype wire
